// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// Each macro is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another condition in the same cycle.
`define ASSERT_SAME(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/core/lcdseq_pkg.sv =====
package lcdseq_pkg;

	typedef enum logic [2:0] {
		REQ_CHAR   = 3'd0,
		REQ_GOTO   = 3'd1,
		REQ_CURSOR = 3'd2,
		REQ_BLINK  = 3'd3,
		REQ_LEFT   = 3'd4,
		REQ_RIGHT  = 3'd5,
		REQ_INIT   = 3'd6,
		REQ_NONE   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		CFG_PULSE_WIDTH = 2'd0,
		CFG_CMD_WAIT    = 2'd1,
		CFG_LONG_WAIT   = 2'd2,
		CFG_POWER_UP    = 2'd3
	} cfg_idx_t;

	// display commands
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_DISP_OFF = 8'h08;
	localparam logic [7:0] CTRL_RESET   = 8'h0C;
	localparam logic [7:0] CMD_SHIFT_L  = 8'h10;
	localparam logic [7:0] CMD_SHIFT_R  = 8'h14;
	localparam logic [7:0] CMD_FUNC_SET = 8'h38;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;
	localparam logic [7:0] ROW1_OFFSET  = 8'h40;

	// display-control bits
	localparam int CTRL_CURSOR_BIT = 1;
	localparam int CTRL_BLINK_BIT  = 0;

	// register reset values
	localparam logic [15:0] PULSE_WIDTH_RST = 16'd1;
	localparam logic [15:0] CMD_WAIT_RST    = 16'd50;
	localparam logic [15:0] LONG_WAIT_RST   = 16'd2000;
	localparam logic [15:0] POWER_UP_RST    = 16'd20000;

	// phase counter: init runs phases 0..10, a single write runs 0..1
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PHASE_INIT_LAST  = 4'd10;
	localparam logic [PHASE_W-1:0] PHASE_WRITE_LAST = 4'd1;

endpackage

// ===== rtl/core/char_lcd_command_sequencer_unit.sv =====
// Command sequencer for an 8-bit parallel two-line character display. Each request on
// the input channel (put char, goto row/column, cursor visible, blink, shift left,
// shift right, init) becomes a run of pin phases on the output channel; every phase
// gives RS, the data bus, E and a hold time in microseconds, and last_phase marks the
// final phase of a request. A byte write is two phases (E high for pulse_width_us,
// then E low for command_wait_us, or long_wait_us after clear or home); init is one
// power-up phase with all pins low followed by five writes, eleven phases in all.
// Request code 7 is taken and dropped without output. One phase leaves per clock
// while the output is not stalled, and the phase counter of the request register
// walks the phases of each request. The next request is taken in the same cycle in
// which the final phase of the current one moves to the output register, so requests
// flow back to back. Timing registers are written through the cfg port, which is
// always ready; write them only while the block is idle.
module char_lcd_command_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic        row_index,
	input  logic [3:0]  column_index,
	input  logic        enable_flag,
	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// pin phase channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_select,
	output logic [7:0]  bus_value,
	output logic        strobe_res,
	output logic [15:0] hold_us,
	output logic        last_phase
);

	// timing registers
	logic [15:0] pulse_width_q;
	logic [15:0] cmd_wait_q;
	logic [15:0] long_wait_q;
	logic [15:0] power_up_q;

	// display-control byte kept across requests
	logic [7:0] display_control_q;
	logic [7:0] dc_next;

	// request register: one decoded request, walked phase by phase
	logic                        valid_s1;
	logic                        init_s1;
	logic                        rs_s1;
	logic [7:0]                  byte_s1;
	logic [lcdseq_pkg::PHASE_W-1:0] phase_s1;

	// output register
	logic        out_valid_q;
	logic        rs_q;
	logic [7:0]  bus_q;
	logic        strobe_q;
	logic [15:0] hold_q;
	logic        last_q;

	// handshake
	logic advance;
	logic emit;
	logic finish;
	logic accept;
	logic load;

	// request decode
	lcdseq_pkg::req_t req;
	logic             dec_rs;
	logic [7:0]       dec_byte;

	// phase generation
	logic [lcdseq_pkg::PHASE_W-1:0] phase_m1;
	logic [7:0]                     cur_byte;
	logic                           cur_strobe;
	logic                           cur_last;
	logic [15:0]                    cur_hold;
	logic                           long_cmd;

	// The output register moves when empty or when its phase is taken.
	assign advance  = !out_valid_q || !out_stall;
	assign emit     = valid_s1 && advance;
	assign finish   = emit && cur_last;
	// Take a new request when the request register is free or hands off its last phase.
	assign in_stall = valid_s1 && !finish;
	assign accept   = in_valid && !in_stall;
	assign req      = lcdseq_pkg::req_t'(req_type);
	// Drop the unused request code: accept it, load nothing.
	assign load     = accept && (req != lcdseq_pkg::REQ_NONE);

	assign cfg_ready = 1'b1;

	// Decode the request into RS and the byte to write; update display control here
	// so that requests see it in arrival order.
	always_comb begin
		dc_next  = display_control_q;
		dec_rs   = 1'b0;
		dec_byte = display_control_q;
		unique case (req)
			lcdseq_pkg::REQ_CHAR: begin
				dec_rs   = 1'b1;
				dec_byte = char_code;
			end
			lcdseq_pkg::REQ_GOTO: begin
				dec_byte = lcdseq_pkg::CMD_DDRAM
					| (row_index ? lcdseq_pkg::ROW1_OFFSET : 8'h00)
					| {4'h0, column_index};
			end
			lcdseq_pkg::REQ_CURSOR: begin
				dc_next[lcdseq_pkg::CTRL_CURSOR_BIT] = enable_flag;
				dec_byte = dc_next;
			end
			lcdseq_pkg::REQ_BLINK: begin
				dc_next[lcdseq_pkg::CTRL_BLINK_BIT] = enable_flag;
				dec_byte = dc_next;
			end
			lcdseq_pkg::REQ_LEFT: begin
				dec_byte = lcdseq_pkg::CMD_SHIFT_L;
			end
			lcdseq_pkg::REQ_RIGHT: begin
				dec_byte = lcdseq_pkg::CMD_SHIFT_R;
			end
			// init ends with the current display control byte
			lcdseq_pkg::REQ_INIT: begin
				dec_byte = display_control_q;
			end
			default: begin
				dec_byte = display_control_q;
			end
		endcase
	end

	// Build the current phase. Init: phase 0 is the power-up wait, then odd phases
	// raise E and even phases lower it for each of the five commands.
	assign phase_m1 = phase_s1 - 4'd1;

	always_comb begin
		cur_byte = byte_s1;
		if (init_s1) begin
			case (phase_m1[3:1])
				3'd0:    cur_byte = lcdseq_pkg::CMD_FUNC_SET;
				3'd1:    cur_byte = lcdseq_pkg::CMD_DISP_OFF;
				3'd2:    cur_byte = lcdseq_pkg::CMD_CLEAR;
				3'd3:    cur_byte = lcdseq_pkg::CMD_ENTRY;
				default: cur_byte = byte_s1;
			endcase
			if (phase_s1 == '0) begin
				cur_byte = 8'h00;
			end
		end
	end

	assign cur_strobe = init_s1 ? phase_s1[0] : !phase_s1[0];
	assign cur_last   = init_s1 ? (phase_s1 == lcdseq_pkg::PHASE_INIT_LAST)
		: (phase_s1 == lcdseq_pkg::PHASE_WRITE_LAST);
	// clear and home need the long settle time
	assign long_cmd   = !rs_s1 && ((cur_byte == lcdseq_pkg::CMD_CLEAR)
		|| (cur_byte == lcdseq_pkg::CMD_HOME));

	always_comb begin
		if (init_s1 && (phase_s1 == '0)) begin
			cur_hold = power_up_q;
		end else if (cur_strobe) begin
			cur_hold = pulse_width_q;
		end else if (long_cmd) begin
			cur_hold = long_wait_q;
		end else begin
			cur_hold = cmd_wait_q;
		end
	end

	// Control state: request valid, phase count, display control, timing registers, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			phase_s1          <= '0;
			display_control_q <= lcdseq_pkg::CTRL_RESET;
			pulse_width_q     <= lcdseq_pkg::PULSE_WIDTH_RST;
			cmd_wait_q        <= lcdseq_pkg::CMD_WAIT_RST;
			long_wait_q       <= lcdseq_pkg::LONG_WAIT_RST;
			power_up_q        <= lcdseq_pkg::POWER_UP_RST;
			out_valid_q       <= 1'b0;
		end else begin
			if (load) begin
				valid_s1          <= 1'b1;
				phase_s1          <= '0;
				display_control_q <= dc_next;
			end else if (finish) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				phase_s1 <= phase_s1 + 4'd1;
			end
			if (advance) begin
				out_valid_q <= emit;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (lcdseq_pkg::cfg_idx_t'(cfg_index))
					lcdseq_pkg::CFG_PULSE_WIDTH: pulse_width_q <= cfg_data;
					lcdseq_pkg::CFG_CMD_WAIT:    cmd_wait_q    <= cfg_data;
					lcdseq_pkg::CFG_LONG_WAIT:   long_wait_q   <= cfg_data;
					lcdseq_pkg::CFG_POWER_UP:    power_up_q    <= cfg_data;
					default:                     power_up_q    <= power_up_q;
				endcase
			end
		end
	end

	// Payload: capture the decoded request and the phase going out.
	always_ff @(posedge clk) begin
		if (load) begin
			init_s1 <= (req == lcdseq_pkg::REQ_INIT);
			rs_s1   <= dec_rs;
			byte_s1 <= dec_byte;
		end
		if (emit) begin
			rs_q     <= rs_s1;
			bus_q    <= cur_byte;
			strobe_q <= cur_strobe;
			hold_q   <= cur_hold;
			last_q   <= cur_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign reg_select = rs_q;
	assign bus_value  = bus_q;
	assign strobe_res = strobe_q;
	assign hold_us    = hold_q;
	assign last_phase = last_q;

endmodule

// ===== rtl/core/lcdseq_chk.sv =====
`include "assert_macros.svh"

module lcdseq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        reg_select,
	input logic [7:0]  bus_value,
	input logic        strobe_res,
	input logic        last_phase
);

	// a stalled phase holds its pins
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bus_value) && $stable(strobe_res), "output phase changed while stalled")

	// every request ends with E low
	`ASSERT_SAME(a_last_low, out_valid && last_phase, !strobe_res, "final phase has E high")

	// an E pulse is followed at once by its E-low phase on the same RS and bus
	`ASSERT_NEXT(a_pulse_pair, out_valid && strobe_res && !out_stall, out_valid && !strobe_res && $stable(bus_value) && $stable(reg_select), "E-high phase not followed by matching E-low phase")

	// a clear command sent with E high is never marked as the final phase
	`ASSERT_SAME(a_clear_cmd, out_valid && strobe_res && !reg_select && (bus_value == lcdseq_pkg::CMD_CLEAR), !last_phase, "clear command pulse marked final")

endmodule

bind char_lcd_command_sequencer_unit lcdseq_chk u_lcdseq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.reg_select (reg_select),
	.bus_value  (bus_value),
	.strobe_res (strobe_res),
	.last_phase (last_phase)
);

// ===== tb/char_lcd_command_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps

module char_lcd_command_sequencer_unit_tb;

	// Cycles without any handshake before the run is declared hung. The slowest
	// legal stretch is a long random receiver stall or a drain pause, far below this.
	localparam int WATCHDOG_LIMIT = 2000;
	// Extra cycles to let a dropped request (code 7) leave the block before an
	// idle-only action such as a register write or the end of the run.
	localparam int DRAIN_CYCLES = 16;

	// One pin phase as the block reports it.
	typedef struct packed {
		logic        rs;
		logic [7:0]  bus;
		logic        strobe;
		logic [15:0] hold;
		logic        last;
	} phase_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	lcdseq_pkg::req_t      req_type;
	logic [7:0]            char_code;
	logic                  row_index;
	logic [3:0]            column_index;
	logic                  enable_flag;
	logic                  cfg_valid;
	logic                  cfg_ready;
	lcdseq_pkg::cfg_idx_t  cfg_index;
	logic [15:0]           cfg_data;
	logic                  out_valid;
	logic                  out_stall;
	logic                  reg_select;
	logic [7:0]            bus_value;
	logic                  strobe_res;
	logic [15:0]           hold_us;
	logic                  last_phase;

	// Shadow copies of the timing registers and of the display-control byte.
	logic [15:0] timing_us [4];
	logic [7:0]  display_ctrl_q;

	// Pin phases still owed by the block, oldest first.
	phase_t expected_phases[$];

	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;

	char_lcd_command_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.char_code    (char_code),
		.row_index    (row_index),
		.column_index (column_index),
		.enable_flag  (enable_flag),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reg_select   (reg_select),
		.bus_value    (bus_value),
		.strobe_res   (strobe_res),
		.hold_us      (hold_us),
		.last_phase   (last_phase)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Phase predictor
	// ------------------------------------------------------------------

	function automatic void push_phase(logic rs, logic [7:0] bus, logic strobe,
			logic [15:0] hold);
		phase_t p;
		p.rs     = rs;
		p.bus    = bus;
		p.strobe = strobe;
		p.hold   = hold;
		p.last   = 1'b0;
		expected_phases.push_back(p);
	endfunction

	// A byte write: E high for the pulse width, then E low for the settle wait.
	// Only the clear and home commands get the long wait; data bytes with the
	// same value still get the ordinary one.
	function automatic void push_byte_write(logic rs, logic [7:0] value);
		logic [15:0] settle;
		settle = timing_us[lcdseq_pkg::CFG_CMD_WAIT];
		if (!rs && (value == lcdseq_pkg::CMD_CLEAR || value == lcdseq_pkg::CMD_HOME))
			settle = timing_us[lcdseq_pkg::CFG_LONG_WAIT];
		push_phase(rs, value, 1'b1, timing_us[lcdseq_pkg::CFG_PULSE_WIDTH]);
		push_phase(rs, value, 1'b0, settle);
	endfunction

	// Queue every phase that one accepted request must produce, in order.
	function automatic void predict_phases(lcdseq_pkg::req_t req, logic [7:0] ch,
			logic row, logic [3:0] col, logic en);
		phase_t tail;
		case (req)
			lcdseq_pkg::REQ_CHAR: begin
				push_byte_write(1'b1, ch);
			end
			lcdseq_pkg::REQ_GOTO: begin
				push_byte_write(1'b0, lcdseq_pkg::CMD_DDRAM
					| ((row ? lcdseq_pkg::ROW1_OFFSET : 8'h00) + {4'h0, col}));
			end
			lcdseq_pkg::REQ_CURSOR: begin
				display_ctrl_q[lcdseq_pkg::CTRL_CURSOR_BIT] = en;
				push_byte_write(1'b0, display_ctrl_q);
			end
			lcdseq_pkg::REQ_BLINK: begin
				display_ctrl_q[lcdseq_pkg::CTRL_BLINK_BIT] = en;
				push_byte_write(1'b0, display_ctrl_q);
			end
			lcdseq_pkg::REQ_LEFT: begin
				push_byte_write(1'b0, lcdseq_pkg::CMD_SHIFT_L);
			end
			lcdseq_pkg::REQ_RIGHT: begin
				push_byte_write(1'b0, lcdseq_pkg::CMD_SHIFT_R);
			end
			lcdseq_pkg::REQ_INIT: begin
				// power-up wait with every pin low, then the init commands;
				// the display-control byte is kept, not reset
				push_phase(1'b0, 8'h00, 1'b0, timing_us[lcdseq_pkg::CFG_POWER_UP]);
				push_byte_write(1'b0, lcdseq_pkg::CMD_FUNC_SET);
				push_byte_write(1'b0, lcdseq_pkg::CMD_DISP_OFF);
				push_byte_write(1'b0, lcdseq_pkg::CMD_CLEAR);
				push_byte_write(1'b0, lcdseq_pkg::CMD_ENTRY);
				push_byte_write(1'b0, display_ctrl_q);
			end
			default: begin
				// unused code: no phases, no state change
			end
		endcase
		// mark the final phase of this request
		if (req != lcdseq_pkg::REQ_NONE) begin
			tail = expected_phases.pop_back();
			tail.last = 1'b1;
			expected_phases.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request and register drivers (drive at falling edge, sample at rising)
	// ------------------------------------------------------------------

	// Send one request; idle at random first, hold it until taken, then predict.
	task automatic send_request(lcdseq_pkg::req_t req, logic [7:0] ch, logic row,
			logic [3:0] col, logic en);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		req_type     = req;
		char_code    = ch;
		row_index    = row;
		column_index = col;
		enable_flag  = en;
		in_valid     = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_phases(req, ch, row, col, en);
	endtask

	// Drop valid once no further request follows right away.
	task automatic drop_request();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Wait until every owed phase has come out, then give a dropped request
	// time to leave the block.
	task automatic wait_for_drain();
		drop_request();
		while (expected_phases.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four timing registers; only call this while the block is idle.
	task automatic write_timing(logic [15:0] pulse, logic [15:0] cmd_wait,
			logic [15:0] long_wait, logic [15:0] power_up);
		logic [15:0] values [4];
		values[0] = pulse;
		values[1] = cmd_wait;
		values[2] = long_wait;
		values[3] = power_up;
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_valid = 1'b1;
			cfg_index = lcdseq_pkg::cfg_idx_t'(i);
			cfg_data  = values[i];
			do @(posedge clk); while (!cfg_ready);
			timing_us[i] = values[i];
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_random_request();
		lcdseq_pkg::req_t req;
		int               roll;
		roll = $urandom_range(99);
		// init is long, so keep it rare; a few dropped codes mixed in as noise
		if (roll < 6)
			req = lcdseq_pkg::REQ_INIT;
		else if (roll < 11)
			req = lcdseq_pkg::REQ_NONE;
		else
			req = lcdseq_pkg::req_t'($urandom_range(5));
		send_request(req, 8'($urandom_range(255)), 1'($urandom_range(1)),
			4'($urandom_range(15)), 1'($urandom_range(1)));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every request type once or more at the reset timing values, with the
	// field extremes and the data bytes that look like clear and home.
	task automatic test_directed_requests();
		send_request(lcdseq_pkg::REQ_CHAR,   8'h00, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_CHAR,   8'hFF, 1'b1, 4'hF, 1'b1);
		send_request(lcdseq_pkg::REQ_CHAR,   lcdseq_pkg::CMD_CLEAR, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_CHAR,   lcdseq_pkg::CMD_HOME, 1'b1, 4'h5, 1'b0);
		send_request(lcdseq_pkg::REQ_GOTO,   8'hFF, 1'b0, 4'h0, 1'b1);
		send_request(lcdseq_pkg::REQ_GOTO,   8'h00, 1'b1, 4'hF, 1'b0);
		send_request(lcdseq_pkg::REQ_CURSOR, 8'hAA, 1'b1, 4'hA, 1'b1);
		send_request(lcdseq_pkg::REQ_BLINK,  8'h55, 1'b0, 4'h5, 1'b1);
		// init must replay the modified display-control byte
		send_request(lcdseq_pkg::REQ_INIT,   8'h00, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_CURSOR, 8'h00, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_BLINK,  8'hFF, 1'b1, 4'hF, 1'b0);
		send_request(lcdseq_pkg::REQ_LEFT,   8'hFF, 1'b1, 4'hF, 1'b1);
		send_request(lcdseq_pkg::REQ_RIGHT,  8'h00, 1'b0, 4'h0, 1'b0);
		// unused code, then a request right behind it
		send_request(lcdseq_pkg::REQ_NONE,   8'hFF, 1'b1, 4'hF, 1'b1);
		send_request(lcdseq_pkg::REQ_NONE,   8'h00, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_CHAR,   8'h41, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_INIT,   8'hFF, 1'b1, 4'hF, 1'b1);
		send_request(lcdseq_pkg::REQ_CURSOR, 8'h00, 1'b0, 4'h0, 1'b1);
		wait_for_drain();
	endtask

	// Timing registers at their extremes, with init to show every timing field.
	task automatic test_register_extremes();
		write_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(lcdseq_pkg::REQ_INIT, 8'h00, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_CHAR, 8'h5A, 1'b0, 4'h0, 1'b0);
		wait_for_drain();
		write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(lcdseq_pkg::REQ_INIT, 8'h00, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_GOTO, 8'h00, 1'b1, 4'h7, 1'b0);
		send_request(lcdseq_pkg::REQ_BLINK, 8'h00, 1'b0, 4'h0, 1'b0);
		wait_for_drain();
		write_timing(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_request(lcdseq_pkg::REQ_INIT, 8'h00, 1'b0, 4'h0, 1'b0);
		wait_for_drain();
		write_timing(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		send_request(lcdseq_pkg::REQ_INIT, 8'h00, 1'b0, 4'h0, 1'b0);
		send_request(lcdseq_pkg::REQ_RIGHT, 8'h00, 1'b0, 4'h0, 1'b0);
		wait_for_drain();
	endtask

	// Random requests under fresh random timing values and the given idling.
	// Halfway through, hold the sender until the block has caught up.
	task automatic test_random_requests(int count, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		wait_for_drain();
		write_timing(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)));
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				drop_request();
				while (expected_phases.size() != 0)
					@(posedge clk);
			end
			send_random_request();
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver, phase checker and watchdog
	// ------------------------------------------------------------------

	// Stall the output at random, at the rate the current test asks for.
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	// Compare every accepted phase with the oldest one owed.
	always @(posedge clk) begin : check_phase
		phase_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_phases.size() == 0) begin
				$error("unexpected phase: rs %0b bus %h e %0b hold %0d last %0b",
					reg_select, bus_value, strobe_res, hold_us, last_phase);
				fail_count++;
			end else begin
				want = expected_phases.pop_front();
				if (reg_select !== want.rs) begin
					$error("reg_select: expected %0b, got %0b", want.rs, reg_select);
					fail_count++;
				end
				if (bus_value !== want.bus) begin
					$error("bus_value: expected %h, got %h", want.bus, bus_value);
					fail_count++;
				end
				if (strobe_res !== want.strobe) begin
					$error("strobe_res: expected %0b, got %0b", want.strobe, strobe_res);
					fail_count++;
				end
				if (hold_us !== want.hold) begin
					$error("hold_us: expected %0d, got %0d", want.hold, hold_us);
					fail_count++;
				end
				if (last_phase !== want.last) begin
					$error("last_phase: expected %0b, got %0b", want.last, last_phase);
					fail_count++;
				end
			end
		end
	end

	// Count cycles with no handshake on any channel; end the run if it hangs.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("no handshake for %0d cycles, %0d phases still owed",
			WATCHDOG_LIMIT, expected_phases.size());
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		// drive every input to a known value and hold reset
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = lcdseq_pkg::REQ_CHAR;
		char_code     = 8'h00;
		row_index     = 1'b0;
		column_index  = 4'h0;
		enable_flag   = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = lcdseq_pkg::CFG_PULSE_WIDTH;
		cfg_data      = 16'h0000;
		fail_count    = 0;
		send_idle_pct = 23;
		recv_idle_pct = 87;

		timing_us[lcdseq_pkg::CFG_PULSE_WIDTH] = lcdseq_pkg::PULSE_WIDTH_RST;
		timing_us[lcdseq_pkg::CFG_CMD_WAIT]    = lcdseq_pkg::CMD_WAIT_RST;
		timing_us[lcdseq_pkg::CFG_LONG_WAIT]   = lcdseq_pkg::LONG_WAIT_RST;
		timing_us[lcdseq_pkg::CFG_POWER_UP]    = lcdseq_pkg::POWER_UP_RST;
		display_ctrl_q                         = lcdseq_pkg::CTRL_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first the slow receiver, then the slow sender, then full speed
		test_directed_requests();
		test_register_extremes();
		test_random_requests(110, 23, 87);
		test_random_requests(110, 87, 23);
		test_random_requests(110, 0, 0);
		wait_for_drain();

		if (expected_phases.size() != 0) begin
			$error("%0d phases never arrived", expected_phases.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lcdseq_pkg.sv
rtl/core/char_lcd_command_sequencer_unit.sv
rtl/core/lcdseq_chk.sv
tb/char_lcd_command_sequencer_unit_tb.sv
